// ===== sv/cwd_pkg.sv =====
// Shared types and constants for the calibrated window detector.
`timescale 1ns / 1ps
package cwd_pkg;

  // Default sample width of the ADC readings
  localparam int SAMPLE_BITS_DEFAULT = 10;

  // Configuration port widths
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Register widths and reset values
  localparam int CALIB_W = 8;
  localparam int HOLD_W  = 16;
  localparam logic [CALIB_W-1:0] CALIB_COUNT_RESET = 8'd50;
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET  = 16'd200;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CALIB_COUNT = 8'd0,
    REG_HOLD_TICKS  = 8'd1
  } cfg_reg_e;

  // Item kinds
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  // Live configuration handed to the detector core
  typedef struct packed {
    logic [CALIB_W-1:0] calib_count;
    logic [HOLD_W-1:0]  hold_ticks;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic calibrating;
    logic below_event;
    logic above_event;
    logic switch_on;
  } result_t;

endpackage

// ===== sv/cwd_in_if.sv =====
// Input item channel: op and sample with valid/ready.
`timescale 1ns / 1ps
interface cwd_in_if #(
  parameter int SAMPLE_BITS = cwd_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

// ===== sv/cwd_out_if.sv =====
// Result channel: detector flags with valid/ready.
`timescale 1ns / 1ps
interface cwd_out_if;
  logic valid;
  logic ready;
  logic calibrating;
  logic below_event;
  logic above_event;
  logic switch_on;

  modport source (output valid, output calibrating, output below_event,
                  output above_event, output switch_on, input ready);
  modport sink   (input valid, input calibrating, input below_event,
                  input above_event, input switch_on, output ready);
endinterface

// ===== sv/cwd_cfg_if.sv =====
// Configuration write channel: register index and data with valid/ready.
`timescale 1ns / 1ps
interface cwd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cwd_pkg::CFG_INDEX_W-1:0] index;
  logic [cwd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/cwd_cfg_regs.sv =====
// Configuration registers for calibration length and hold time.
`timescale 1ns / 1ps
module cwd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  cwd_cfg_if.sink       cfg,
  output cwd_pkg::cfg_t cfg_q
);
  import cwd_pkg::*;

  cfg_t regs;

  // Writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;
  assign cfg_q     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.calib_count <= CALIB_COUNT_RESET;
      regs.hold_ticks  <= HOLD_TICKS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CALIB_COUNT: regs.calib_count <= cfg.data[CALIB_W-1:0];
        REG_HOLD_TICKS:  regs.hold_ticks  <= cfg.data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/cwd_in_stage.sv =====
// Input register stage that holds one accepted item for the core.
`timescale 1ns / 1ps
module cwd_in_stage #(
  parameter int SAMPLE_BITS = cwd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  cwd_in_if.sink                 din,
  output logic                   itm_valid,
  input  logic                   itm_ready,
  output logic                   itm_op,
  output logic [SAMPLE_BITS-1:0] itm_sample
);
  import cwd_pkg::*;

  logic                   held;
  logic                   op;
  logic [SAMPLE_BITS-1:0] sample;

  // Take a new transaction when empty or when the core drains this one
  assign din.ready  = !held || itm_ready;
  assign itm_valid  = held;
  assign itm_op     = op;
  assign itm_sample = sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (din.valid && din.ready) begin
      held <= 1'b1;
    end else if (itm_ready) begin
      held <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      op     <= din.op;
      sample <= din.sample;
    end
  end

endmodule

// ===== sv/cwd_core.sv =====
// Detector core: calibration, window compare, hold countdown, result register.
`timescale 1ns / 1ps
module cwd_core #(
  parameter int SAMPLE_BITS = cwd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cwd_pkg::cfg_t          cfg_q,
  input  logic                   itm_valid,
  output logic                   itm_ready,
  input  logic                   itm_op,
  input  logic [SAMPLE_BITS-1:0] itm_sample,
  cwd_out_if.source              dout
);
  import cwd_pkg::*;

  // Detector state
  logic                   calib_phase;
  logic [CALIB_W-1:0]     calib_counter;
  logic [SAMPLE_BITS-1:0] seen_min;
  logic [SAMPLE_BITS-1:0] seen_max;
  logic [SAMPLE_BITS-1:0] lower_bound;
  logic [SAMPLE_BITS:0]   upper_bound;
  logic [HOLD_W-1:0]      hold_count;
  logic                   below_flag;
  logic                   above_flag;

  // Next values
  logic                   calib_phase_next;
  logic [CALIB_W-1:0]     calib_counter_next;
  logic [SAMPLE_BITS-1:0] seen_min_next;
  logic [SAMPLE_BITS-1:0] seen_max_next;
  logic [SAMPLE_BITS-1:0] lower_bound_next;
  logic [SAMPLE_BITS:0]   upper_bound_next;
  logic [HOLD_W-1:0]      hold_count_next;
  logic                   below_flag_next;
  logic                   above_flag_next;
  logic [SAMPLE_BITS-1:0] pad;

  // Result register
  logic    res_valid;
  result_t res;
  logic    advance;

  // Move an item into the result register when that register is free or drains
  assign itm_ready = !res_valid || dout.ready;
  assign advance   = itm_valid && itm_ready;

  // Padding and window from the updated extremes
  always_comb begin
    pad = (seen_max_next >= seen_min_next) ? (seen_max_next - seen_min_next) : '0;
    lower_bound_next = (seen_min_next > pad) ? (seen_min_next - pad) : '0;
    upper_bound_next = {1'b0, seen_max_next} + {1'b0, pad};
  end

  // Apply one item to the state
  always_comb begin
    calib_phase_next   = calib_phase;
    calib_counter_next = calib_counter;
    seen_min_next      = seen_min;
    seen_max_next      = seen_max;
    hold_count_next    = hold_count;
    below_flag_next    = below_flag;
    above_flag_next    = above_flag;
    if (itm_op == OP_TICK) begin
      if (hold_count != '0) begin
        hold_count_next = hold_count - 1'b1;
      end
    end else if (calib_phase) begin
      if (itm_sample > seen_max) begin
        seen_max_next = itm_sample;
      end
      if (itm_sample < seen_min) begin
        seen_min_next = itm_sample;
      end
      calib_counter_next = calib_counter + 1'b1;
      if (calib_counter_next == '0 || calib_counter_next >= cfg_q.calib_count) begin
        calib_phase_next = 1'b0;
      end
    end else if (itm_sample < lower_bound) begin
      below_flag_next = 1'b1;
      above_flag_next = 1'b0;
      hold_count_next = cfg_q.hold_ticks;
    end else if ({1'b0, itm_sample} > upper_bound) begin
      below_flag_next = 1'b0;
      above_flag_next = 1'b1;
      hold_count_next = cfg_q.hold_ticks;
    end else begin
      below_flag_next = 1'b0;
      above_flag_next = 1'b0;
    end
  end

  // Commit state on each advancing item
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_phase   <= 1'b1;
      calib_counter <= '0;
      seen_min      <= '1;
      seen_max      <= '0;
      lower_bound   <= '0;
      upper_bound   <= '0;
      hold_count    <= '0;
      below_flag    <= 1'b0;
      above_flag    <= 1'b0;
    end else if (advance) begin
      calib_phase   <= calib_phase_next;
      calib_counter <= calib_counter_next;
      seen_min      <= seen_min_next;
      seen_max      <= seen_max_next;
      hold_count    <= hold_count_next;
      below_flag    <= below_flag_next;
      above_flag    <= above_flag_next;
      // Latch the window on the sample that ends calibration
      if (calib_phase && !calib_phase_next) begin
        lower_bound <= lower_bound_next;
        upper_bound <= upper_bound_next;
      end
    end
  end

  // Result valid: set by an advancing item, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (dout.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res.calibrating <= calib_phase_next;
      res.below_event <= below_flag_next;
      res.above_event <= above_flag_next;
      res.switch_on   <= (hold_count_next != '0);
    end
  end

  assign dout.valid       = res_valid;
  assign dout.calibrating = res.calibrating;
  assign dout.below_event = res.below_event;
  assign dout.above_event = res.above_event;
  assign dout.switch_on   = res.switch_on;

`ifndef SYNTH
  // Calibration never restarts without a reset
  a_calib_once: assert property (@(posedge clk) disable iff (rst)
    !calib_phase |=> !calib_phase)
    else $error("calibration phase re-entered");

  // The two event flags are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(below_flag && above_flag))
    else $error("below and above flags both set");

  // No events during calibration
  a_no_event_calib: assert property (@(posedge clk) disable iff (rst)
    calib_phase |-> (!below_flag && !above_flag))
    else $error("event flag set while calibrating");

  // The window is well ordered once calibrated
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    !calib_phase |-> ({1'b0, lower_bound} <= upper_bound))
    else $error("lower bound above upper bound");
`endif

endmodule

// ===== sv/calibrated_window_detector_hold_unit.sv =====
// Top level of the calibrated window detector with hold timer.
//
// Usage:
//   din  carries items: op selects an ADC sample or one time tick.
//   dout returns one result per item: calibrating, below_event,
//        above_event and switch_on, as they stand after that item.
//   cfg  writes register 0 (calibration length) and 1 (hold ticks);
//        it is always ready and writes are meant for idle periods.
// Path: an accepted item is held first in the input register and then in the
//   result register, which drives dout.valid.
// Throughput: one item per cycle while dout is taken; the window compare, the
//   calibration update and the countdown step fit between the two registers.
// Reset: configuration returns to 50 samples and 200 ticks, calibration
//   restarts and the countdown is cleared; no clearing pass is needed.
// Stall: when dout is not taken, the result register holds and the input
//   register keeps one more item; din.ready drops only when both are full.
`timescale 1ns / 1ps
module calibrated_window_detector_hold_unit #(
  parameter int SAMPLE_BITS = cwd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  cwd_in_if.sink    din,
  cwd_out_if.source dout,
  cwd_cfg_if.sink   cfg
);
  import cwd_pkg::*;

  cfg_t                   cfg_q;
  logic                   itm_valid;
  logic                   itm_ready;
  logic                   itm_op;
  logic [SAMPLE_BITS-1:0] itm_sample;

  cwd_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  cwd_in_stage #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .itm_valid  (itm_valid),
    .itm_ready  (itm_ready),
    .itm_op     (itm_op),
    .itm_sample (itm_sample)
  );

  cwd_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_q      (cfg_q),
    .itm_valid  (itm_valid),
    .itm_ready  (itm_ready),
    .itm_op     (itm_op),
    .itm_sample (itm_sample),
    .dout       (dout)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the calibrated window detector with hold timer.
`timescale 1ns / 1ps
module testbench;
  import cwd_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEFAULT;
  localparam int SAMPLE_TOP   = (1 << SB) - 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int STALL_CYCLES = 120;
  localparam int PHASE_ITEMS  = 150;

  // Indexes that no register answers to
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE  = 8'hFF;

  // Tracks the detector state and the flags each accepted item must produce
  class flag_tracker;
    logic [CALIB_W-1:0] calib_len;
    logic [HOLD_W-1:0]  hold_reload;
    bit                 learning;
    logic [7:0]         learned_cnt;
    logic [SB-1:0]      trough;
    logic [SB-1:0]      peak;
    logic [SB-1:0]      floor_lvl;
    logic [SB:0]        ceiling_lvl;
    logic [HOLD_W-1:0]  hold_left;
    bit                 low_flag;
    bit                 high_flag;
    result_t            flags_due[$];
    int                 mismatches;
    int                 items_seen;
    int                 ticks_seen;
    int                 results_checked;
    int                 low_hits;
    int                 high_hits;

    function new();
      calib_len       = CALIB_COUNT_RESET;
      hold_reload     = HOLD_TICKS_RESET;
      learning        = 1'b1;
      learned_cnt     = '0;
      trough          = '1;
      peak            = '0;
      floor_lvl       = '0;
      ceiling_lvl     = '0;
      hold_left       = '0;
      low_flag        = 1'b0;
      high_flag       = 1'b0;
      mismatches      = 0;
      items_seen      = 0;
      ticks_seen      = 0;
      results_checked = 0;
      low_hits        = 0;
      high_hits       = 0;
    endfunction

    function void flag_error(string what);
      mismatches++;
      $display("MISMATCH at result %0d: %s", results_checked, what);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CALIB_COUNT) calib_len = data[CALIB_W-1:0];
      else if (idx == REG_HOLD_TICKS) hold_reload = data[HOLD_W-1:0];
    endfunction

    // Apply one accepted item and queue the flags it leaves behind
    function void take_item(op_e op, logic [SB-1:0] s);
      logic [SB-1:0] pad;
      result_t       due;
      items_seen++;
      if (op == OP_TICK) begin
        ticks_seen++;
        if (hold_left != 0) hold_left--;
      end else if (learning) begin
        if (s > peak) peak = s;
        if (s < trough) trough = s;
        learned_cnt = learned_cnt + 8'd1;
        if (learned_cnt == 0 || learned_cnt >= calib_len) begin
          // close calibration: pad the window by the spread on both sides
          pad         = (peak >= trough) ? peak - trough : '0;
          floor_lvl   = (trough > pad) ? trough - pad : '0;
          ceiling_lvl = {1'b0, peak} + {1'b0, pad};
          learning    = 1'b0;
        end
      end else if (s < floor_lvl) begin
        low_flag  = 1'b1;
        high_flag = 1'b0;
        hold_left = hold_reload;
        low_hits++;
      end else if ({1'b0, s} > ceiling_lvl) begin
        low_flag  = 1'b0;
        high_flag = 1'b1;
        hold_left = hold_reload;
        high_hits++;
      end else begin
        low_flag  = 1'b0;
        high_flag = 1'b0;
      end
      due.calibrating = learning;
      due.below_event = low_flag;
      due.above_event = high_flag;
      due.switch_on   = (hold_left != 0);
      flags_due.push_back(due);
    endfunction

    // Compare one accepted result with the oldest pending flags
    function void check_flags(result_t got);
      string   names[4] = '{"calibrating", "below_event", "above_event", "switch_on"};
      result_t due;
      if (flags_due.size() == 0) begin
        flag_error("result arrived with nothing pending");
        return;
      end
      due = flags_due.pop_front();
      for (int b = 0; b < 4; b++)
        if (got[3-b] !== due[3-b])
          flag_error($sformatf("%s got %b, want %b", names[b], got[3-b], due[3-b]));
      results_checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  bit          steady;
  bit          stall_request;
  int          cycle_count;
  flag_tracker tracker = new();

  cwd_in_if #(.SAMPLE_BITS(SB)) din_bus ();
  cwd_out_if                    dout_bus ();
  cwd_cfg_if                    cfg_bus ();

  calibrated_window_detector_hold_unit #(.SAMPLE_BITS(SB)) i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus),
    .cfg  (cfg_bus)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending",
               cycle_count, tracker.flags_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  function automatic logic [SB-1:0] near(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_TOP) return '1;
    return SB'(v);
  endfunction

  // Offer one item from a falling edge until accepted; return at a falling edge
  task automatic send_item(op_e op, logic [SB-1:0] s);
    while (idle_now()) begin
      din_bus.valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    din_bus.valid  <= 1'b1;
    din_bus.op     <= op;
    din_bus.sample <= s;
    do @(posedge clk); while (!din_bus.ready);
    tracker.take_item(op, s);
    @(negedge clk);
  endtask

  // One register write transaction; valid then drops and stays low before the task returns
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and drain every pending result, then cover the pipeline
  task automatic settle();
    din_bus.valid <= 1'b0;
    while (tracker.flags_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result side: random idling, one long hold-off, check each transaction
  initial begin : result_sink
    result_t got;
    int      stall_left;
    dout_bus.ready = 1'b0;
    stall_left     = 0;
    @(negedge clk);
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (stall_request && stall_left == 0) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (stall_left != 0) begin
        dout_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        dout_bus.ready <= !idle_now();
      end
      @(posedge clk);
      if (dout_bus.valid && dout_bus.ready) begin
        got = {dout_bus.calibrating, dout_bus.below_event,
               dout_bus.above_event, dout_bus.switch_on};
        tracker.check_flags(got);
      end
    end
  end

  initial begin : stimulus
    int                    centre;
    int                    spread;
    int                    choice;
    int                    v;
    logic [CFG_DATA_W-1:0] hold_pick;
    din_bus.valid  = 1'b0;
    din_bus.op     = OP_SAMPLE;
    din_bus.sample = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_CALIB_COUNT;
    cfg_bus.data   = '0;
    steady         = 1'b0;
    stall_request  = 1'b0;
    rst            = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero hold, longest calibration; the count carries spare upper bits
    write_reg(REG_HOLD_TICKS, 16'd0);
    write_reg(REG_CALIB_COUNT, 16'hFFFF);
    centre = ($urandom_range(3) == 0) ? $urandom_range(0, 20) : $urandom_range(40, 900);
    spread = $urandom_range(1, 30);
    send_item(OP_TICK, '0);
    send_item(OP_SAMPLE, SB'(centre + spread));
    send_item(OP_SAMPLE, SB'(centre));
    send_item(OP_TICK, '1);
    settle();

    // A zero count closes calibration on the next sample
    write_reg(REG_CALIB_COUNT, 16'd0);
    send_item(OP_SAMPLE, SB'(centre + spread / 2));

    // Extremes and window edges with a zero hold; ticks keep the flags
    send_item(OP_SAMPLE, '0);
    send_item(OP_TICK, '0);
    send_item(OP_SAMPLE, '1);
    send_item(OP_TICK, '1);
    send_item(OP_SAMPLE, tracker.floor_lvl);
    send_item(OP_SAMPLE, near(int'(tracker.floor_lvl) - 1));
    send_item(OP_SAMPLE, near(int'(tracker.ceiling_lvl)));
    send_item(OP_SAMPLE, near(int'(tracker.ceiling_lvl) + 1));
    send_item(OP_SAMPLE, SB'(centre));
    settle();

    // Shortest and longest hold, then writes that must change nothing
    write_reg(REG_HOLD_TICKS, 16'd1);
    send_item(OP_SAMPLE, '1);
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '0);
    settle();
    write_reg(REG_HOLD_TICKS, 16'hFFFF);
    send_item(OP_SAMPLE, '0);
    send_item(OP_TICK, '1);
    settle();
    write_reg(REG_SPARE, 16'h1234);
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_CALIB_COUNT, 16'd7);
    send_item(OP_TICK, '0);
    send_item(OP_SAMPLE, SB'(centre));

    // Random phases, each with its own hold setting
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: hold_pick = 16'($urandom_range(1, 8));
        1: hold_pick = 16'($urandom_range(1, 40));
        2: hold_pick = 16'hFFFF;
        3: hold_pick = 16'd0;
        4: hold_pick = 16'($urandom_range(1, 8));
        default: hold_pick = 16'($urandom_range(1, 300));
      endcase
      write_reg(REG_HOLD_TICKS, hold_pick);
      write_reg(REG_CALIB_COUNT, 16'($urandom));
      steady = (phase == 1);
      if (phase == 4) stall_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        choice = $urandom_range(99);
        if (choice < 35) begin
          send_item(OP_TICK, SB'($urandom));
        end else begin
          // aim mostly at the window edges, the rest anywhere
          if (choice < 55) v = int'(tracker.floor_lvl) + int'($urandom_range(0, 2)) - 1;
          else if (choice < 75) v = int'(tracker.ceiling_lvl) + int'($urandom_range(0, 2)) - 1;
          else if (choice < 80) v = ($urandom_range(1) == 0) ? 0 : SAMPLE_TOP;
          else v = $urandom_range(0, SAMPLE_TOP);
          send_item(OP_SAMPLE, near(v));
        end
      end
    end
    steady = 1'b0;

    // Drain and look for stray results
    settle();
    repeat (8) @(negedge clk);
    if (tracker.flags_due.size() != 0)
      tracker.flag_error($sformatf("%0d results never arrived", tracker.flags_due.size()));

    $display("Run covered %0d items (%0d ticks), %0d checked results, %0d below and %0d above triggers.",
             tracker.items_seen, tracker.ticks_seen, tracker.results_checked,
             tracker.low_hits, tracker.high_hits);
    $display("Holds of 0, 1 and 65535 ticks, a zero calibration count and a %0d-cycle output hold-off were included.",
             STALL_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
